// File: rtl/multi_ant_langton_step_macros.svh
// Assertion helpers for the multi-ant Langton step block.
`ifndef MULTI_ANT_LANGTON_STEP_MACROS_SVH
`define MULTI_ANT_LANGTON_STEP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MALS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MALS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MALS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MALS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/mals_pkg.sv
package mals_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_CELL = 2'd0,
    ACT_PLACE_ANT  = 2'd1,
    ACT_TICK       = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    HD_UP    = 2'd0,
    HD_RIGHT = 2'd1,
    HD_DOWN  = 2'd2,
    HD_LEFT  = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_CELL_RD = 2'd1,
    ST_EXEC    = 2'd2
  } state_t;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND  = 2'd2;
  localparam logic [1:0] CFG_ANT_COUNT   = 2'd3;

  // heading increments modulo the four directions
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd3;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

endpackage

// File: rtl/mals_ram.sv
module mals_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mals_move.sv
module mals_move #(
  parameter int XW = 7,
  parameter int YW = 7,
  parameter int WDW = 8,
  parameter int HDW = 8,
  parameter int COLOR_BITS = 24
) (
  input  logic [XW-1:0]         x,
  input  logic [YW-1:0]         y,
  input  mals_pkg::heading_t    hd,
  input  logic [COLOR_BITS-1:0] ant_color,
  input  logic [COLOR_BITS-1:0] cell_col,
  input  logic [COLOR_BITS-1:0] bg,
  input  logic [WDW-1:0]        eff_w,
  input  logic [HDW-1:0]        eff_h,
  output logic [XW-1:0]         nx,
  output logic [YW-1:0]         ny,
  output mals_pkg::heading_t    dir,
  output logic [COLOR_BITS-1:0] paint
);
  import mals_pkg::*;

  logic          empty;
  logic [WDW-1:0] xw;
  logic [HDW-1:0] yw;

  assign empty = (cell_col == bg);
  assign paint = empty ? ant_color : bg;
  assign dir   = heading_t'(hd + (empty ? TURN_RIGHT : TURN_LEFT));
  assign xw    = WDW'(x);
  assign yw    = HDW'(y);

  // step one cell with wraparound at the active grid edges
  always_comb begin
    nx = x;
    ny = y;
    case (dir)
      HD_UP:    ny = (yw == '0) ? YW'(eff_h - HDW'(1)) : YW'(yw - HDW'(1));
      HD_RIGHT: nx = ((xw + WDW'(1)) == eff_w) ? '0 : XW'(xw + WDW'(1));
      HD_DOWN:  ny = ((yw + HDW'(1)) == eff_h) ? '0 : YW'(yw + HDW'(1));
      HD_LEFT:  nx = (xw == '0) ? XW'(eff_w - WDW'(1)) : XW'(xw - WDW'(1));
      default:  nx = x;
    endcase
  end

endmodule

// File: rtl/multi_ant_langton_step.sv
// Multi-ant Langton's ant on a wrapping colour grid. An input request writes
// one grid cell or places one ant; a tick request walks ants 0 .. n-1 in
// order, n being ant_count clamped to MAX_ANTS, and returns one result per
// ant, the last one flagged. A tick occupies the block until the last ant
// is done, and longer while the output sits stalled: each ant first reads
// its table entry into the grid address, then reads, repaints and writes
// back its cell through the one grid memory, and the input is stalled
// meanwhile. Grid and ant storage are not cleared by reset; every
// cell and ant used must be written before the first tick. Configuration is
// always ready and must only be written while the block is idle.
`include "multi_ant_langton_step_macros.svh"

module multi_ant_langton_step #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_ANTS   = 16,
  parameter int COLOR_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mals_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mals_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic [6:0]                           cell_x,
  input  logic [6:0]                           cell_y,
  input  logic [23:0]                          color,
  input  logic [3:0]                           ant_slot,
  input  logic [1:0]                           heading,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [3:0]                           ant_id,
  output logic [6:0]                           new_x,
  output logic [6:0]                           new_y,
  output logic [1:0]                           new_heading,
  output logic [23:0]                          painted_color,
  output logic                                 last
);
  import mals_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WDW    = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
  localparam int HDW    = ($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8;
  localparam int GDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int AW     = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int CNW    = ($clog2(MAX_ANTS + 1) > 5) ? $clog2(MAX_ANTS + 1) : 5;
  localparam int AEW    = XW + YW + 2 + COLOR_BITS;

  // configuration registers
  logic [7:0]  grid_width;
  logic [7:0]  grid_height;
  logic [23:0] background_color;
  logic [4:0]  ant_count;

  logic [WDW-1:0]        eff_w;
  logic [HDW-1:0]        eff_h;
  logic [CNW-1:0]        n_eff;
  logic [COLOR_BITS-1:0] bg;

  state_t state;
  state_t state_next;

  logic [AW-1:0]         idx;
  logic [XW-1:0]         cur_x;
  logic [YW-1:0]         cur_y;
  heading_t              cur_hd;
  logic [COLOR_BITS-1:0] cur_col;
  logic [GAW-1:0]        cell_idx;

  logic    in_acc;
  action_t act;
  logic    in_ok;
  logic    slot_ok;
  logic    start;
  logic    out_free;
  logic    proceed;
  logic    is_last;

  logic [AW-1:0]  ant_raddr;
  logic [AW-1:0]  ant_waddr;
  logic [AEW-1:0] ant_wdata;
  logic [AEW-1:0] ant_q;
  logic           ant_we;

  logic [GAW-1:0]        grid_raddr;
  logic [GAW-1:0]        grid_waddr;
  logic [COLOR_BITS-1:0] grid_wdata;
  logic [COLOR_BITS-1:0] grid_q;
  logic                  grid_we;
  logic [GAW-1:0]        in_addr;

  logic [XW-1:0]         q_x;
  logic [YW-1:0]         q_y;
  logic [1:0]            q_hd;
  logic [COLOR_BITS-1:0] q_col;
  logic [XW-1:0]         start_x;
  logic [YW-1:0]         start_y;
  logic [GAW-1:0]        start_addr;

  logic [XW-1:0]         mv_x;
  logic [YW-1:0]         mv_y;
  heading_t              mv_dir;
  logic [COLOR_BITS-1:0] mv_paint;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= 8'd128;
      grid_height      <= 8'd128;
      background_color <= '0;
      ant_count        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width       <= cfg_data[7:0];
        CFG_GRID_HEIGHT: grid_height      <= cfg_data[7:0];
        CFG_BACKGROUND:  background_color <= cfg_data[23:0];
        CFG_ANT_COUNT:   ant_count        <= cfg_data[4:0];
        default:         grid_width       <= grid_width;
      endcase
    end
  end

  // clamp sizes to [1, max] and the ant count to the table depth
  always_comb begin
    if (grid_width == '0) begin
      eff_w = WDW'(1);
    end else if (WDW'(grid_width) > WDW'(MAX_WIDTH)) begin
      eff_w = WDW'(MAX_WIDTH);
    end else begin
      eff_w = WDW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HDW'(1);
    end else if (HDW'(grid_height) > HDW'(MAX_HEIGHT)) begin
      eff_h = HDW'(MAX_HEIGHT);
    end else begin
      eff_h = HDW'(grid_height);
    end
    n_eff = (CNW'(ant_count) > CNW'(MAX_ANTS)) ? CNW'(MAX_ANTS) : CNW'(ant_count);
  end

  assign bg = COLOR_BITS'(background_color);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign act      = action_t'(action);
  assign in_ok    = (WDW'(cell_x) < eff_w) && (HDW'(cell_y) < eff_h);
  assign slot_ok  = CNW'(ant_slot) < CNW'(MAX_ANTS);
  assign start    = in_acc && (act == ACT_TICK) && (n_eff != '0);
  assign in_addr  = GAW'(GAW'(YW'(cell_y)) * GAW'(MAX_WIDTH) + GAW'(XW'(cell_x)));

  assign out_free = !out_valid || !out_stall;
  assign proceed  = (state == ST_EXEC) && out_free;
  assign is_last  = (CNW'(idx) + CNW'(1)) == n_eff;

  // unpack the ant entry read for the current index; drop stale coordinates
  assign {q_x, q_y, q_hd, q_col} = ant_q;
  assign start_x    = (WDW'(q_x) < eff_w) ? q_x : '0;
  assign start_y    = (HDW'(q_y) < eff_h) ? q_y : '0;
  assign start_addr = GAW'(GAW'(start_y) * GAW'(MAX_WIDTH) + GAW'(start_x));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_CELL_RD;
      ST_CELL_RD: state_next = ST_EXEC;
      ST_EXEC:    if (proceed) state_next = is_last ? ST_IDLE : ST_CELL_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ant_raddr  = idx;
    grid_raddr = cell_idx;
    case (state)
      ST_IDLE:    ant_raddr = '0;
      ST_CELL_RD: grid_raddr = start_addr;
      ST_EXEC:    ant_raddr = AW'(idx + AW'(1));
      default:    ant_raddr = idx;
    endcase

    ant_we    = proceed || (in_acc && (act == ACT_PLACE_ANT) && slot_ok && in_ok);
    ant_waddr = proceed ? idx : AW'(ant_slot);
    ant_wdata = proceed ? {mv_x, mv_y, mv_dir, cur_col}
                        : {XW'(cell_x), YW'(cell_y), heading, COLOR_BITS'(color)};

    grid_we    = proceed || (in_acc && (act == ACT_WRITE_CELL) && in_ok);
    grid_waddr = proceed ? cell_idx : in_addr;
    grid_wdata = proceed ? mv_paint : COLOR_BITS'(color);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (start) begin
      idx <= '0;
    end else if (proceed && !is_last) begin
      idx <= AW'(idx + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CELL_RD) begin
      cur_x    <= start_x;
      cur_y    <= start_y;
      cur_hd   <= heading_t'(q_hd);
      cur_col  <= q_col;
      cell_idx <= start_addr;
    end
  end

  // output register: load on each finished ant, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      ant_id        <= 4'(idx);
      new_x         <= 7'(mv_x);
      new_y         <= 7'(mv_y);
      new_heading   <= mv_dir;
      painted_color <= 24'(mv_paint);
      last          <= is_last;
    end
  end

  mals_ram #(
    .DEPTH(MAX_ANTS),
    .WIDTH(AEW)
  ) u_ant_ram (
    .clk  (clk),
    .we   (ant_we),
    .waddr(ant_waddr),
    .wdata(ant_wdata),
    .raddr(ant_raddr),
    .rdata(ant_q)
  );

  mals_ram #(
    .DEPTH(GDEPTH),
    .WIDTH(COLOR_BITS)
  ) u_grid_ram (
    .clk  (clk),
    .we   (grid_we),
    .waddr(grid_waddr),
    .wdata(grid_wdata),
    .raddr(grid_raddr),
    .rdata(grid_q)
  );

  mals_move #(
    .XW        (XW),
    .YW        (YW),
    .WDW       (WDW),
    .HDW       (HDW),
    .COLOR_BITS(COLOR_BITS)
  ) u_move (
    .x        (cur_x),
    .y        (cur_y),
    .hd       (cur_hd),
    .ant_color(cur_col),
    .cell_col (grid_q),
    .bg       (bg),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .nx       (mv_x),
    .ny       (mv_y),
    .dir      (mv_dir),
    .paint    (mv_paint)
  );

  `MALS_ASSERT_NEXT(a_tick_starts, clk, rst, start, state == ST_CELL_RD, "tick did not start")
  `MALS_ASSERT_NEXT(a_read_to_exec, clk, rst, state == ST_CELL_RD, state == ST_EXEC, "cell read not followed by update")
  `MALS_ASSERT_NEXT(a_exec_waits, clk, rst, (state == ST_EXEC) && out_valid && out_stall, (state == ST_EXEC) && out_valid, "update ran over a waiting result")
  `MALS_ASSERT_IMPLY(a_busy_stalls, clk, rst, state == ST_EXEC, in_stall, "input taken during a tick")

endmodule

// File: verif/tb_multi_ant_langton_step.sv
`timescale 1ns / 1ps

module tb_multi_ant_langton_step;
  import mals_pkg::*;

  localparam int GRID_STRIDE = 128;
  localparam int GRID_CELLS  = 128 * 128;
  localparam int ANT_SLOTS   = 16;
  localparam int ITEM_TARGET = 120;

  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_RUNS   = 2;

  typedef struct {
    bit [6:0]  x;
    bit [6:0]  y;
    heading_t  hd;
    bit [23:0] paint_col;
  } ant_rec_t;

  typedef struct {
    bit [3:0]  id;
    bit [6:0]  x;
    bit [6:0]  y;
    heading_t  hd;
    bit [23:0] paint;
    bit        last;
  } ant_move_t;

  class langton_scoreboard;
    bit [23:0]  grid_mirror [GRID_CELLS];
    bit         cell_known [GRID_CELLS];
    ant_rec_t   ants [ANT_SLOTS];
    bit         ant_known [ANT_SLOTS];
    bit [7:0]   width_reg;
    bit [7:0]   height_reg;
    bit [23:0]  bg_reg;
    bit [4:0]   count_reg;
    ant_move_t  pending_moves [$];
    int         errors;
    int         checked;
    int         ticks;

    function new();
      width_reg  = 8'd128;
      height_reg = 8'd128;
      bg_reg     = '0;
      count_reg  = '0;
    endfunction

    function int width_eff();
      return (width_reg == 0) ? 1 : (width_reg > 128) ? 128 : int'(width_reg);
    endfunction

    function int height_eff();
      return (height_reg == 0) ? 1 : (height_reg > 128) ? 128 : int'(height_reg);
    endfunction

    function int active_ants();
      return (count_reg > ANT_SLOTS) ? ANT_SLOTS : int'(count_reg);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg  = data[7:0];
        CFG_GRID_HEIGHT: height_reg = data[7:0];
        CFG_BACKGROUND:  bg_reg     = data;
        CFG_ANT_COUNT:   count_reg  = data[4:0];
        default: ;
      endcase
    endfunction

    // Mirror one accepted request; a tick queues one move per active ant.
    function void note_request(action_t act, bit [6:0] x, bit [6:0] y, bit [23:0] col,
                               bit [3:0] slot, heading_t hd);
      int        w, h, n, cx, cy, idx;
      bit        blank;
      bit [23:0] paint;
      bit [1:0]  turned;
      heading_t  dir;
      ant_move_t m;
      w = width_eff();
      h = height_eff();
      case (act)
        ACT_WRITE_CELL: begin
          if (x < w && y < h) begin
            idx = int'(y) * GRID_STRIDE + int'(x);
            grid_mirror[idx] = col;
            cell_known[idx]  = 1'b1;
          end
        end
        ACT_PLACE_ANT: begin
          if (x < w && y < h) begin
            ants[slot]      = '{x, y, hd, col};
            ant_known[slot] = 1'b1;
          end
        end
        ACT_TICK: begin
          ticks++;
          n = active_ants();
          for (int i = 0; i < n; i++) begin
            // stale coordinates past the current grid fold to zero
            cx = (ants[i].x < w) ? int'(ants[i].x) : 0;
            cy = (ants[i].y < h) ? int'(ants[i].y) : 0;
            idx = cy * GRID_STRIDE + cx;
            blank = (grid_mirror[idx] == bg_reg);
            paint = blank ? ants[i].paint_col : bg_reg;
            turned = ants[i].hd + (blank ? TURN_RIGHT : TURN_LEFT);
            dir = heading_t'(turned);
            grid_mirror[idx] = paint;
            cell_known[idx]  = 1'b1;
            case (dir)
              HD_UP:    cy = (cy == 0) ? h - 1 : cy - 1;
              HD_RIGHT: cx = (cx + 1 == w) ? 0 : cx + 1;
              HD_DOWN:  cy = (cy + 1 == h) ? 0 : cy + 1;
              default:  cx = (cx == 0) ? w - 1 : cx - 1;
            endcase
            ants[i].x  = 7'(cx);
            ants[i].y  = 7'(cy);
            ants[i].hd = dir;
            m.id    = 4'(i);
            m.x     = 7'(cx);
            m.y     = 7'(cy);
            m.hd    = dir;
            m.paint = paint;
            m.last  = (i == n - 1);
            pending_moves.push_back(m);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [3:0] id, logic [6:0] x, logic [6:0] y,
                               logic [1:0] hd, logic [23:0] paint, logic last_flag);
      ant_move_t m;
      if (pending_moves.size() == 0) begin
        report($sformatf("result for ant %0d with nothing pending", id));
        return;
      end
      m = pending_moves.pop_front();
      checked++;
      if (id !== m.id)
        report($sformatf("ant_id got %0d want %0d", id, m.id));
      if (x !== m.x)
        report($sformatf("ant %0d new_x got %0d want %0d", m.id, x, m.x));
      if (y !== m.y)
        report($sformatf("ant %0d new_y got %0d want %0d", m.id, y, m.y));
      if (hd !== m.hd)
        report($sformatf("ant %0d new_heading got %0d want %0d", m.id, hd, m.hd));
      if (paint !== m.paint)
        report($sformatf("ant %0d painted_color got %06h want %06h", m.id, paint, m.paint));
      if (last_flag !== m.last)
        report($sformatf("ant %0d last got %0b want %0b", m.id, last_flag, m.last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [23:0] color;
  logic [3:0]  ant_slot;
  logic [1:0]  heading;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  ant_id;
  logic [6:0]  new_x;
  logic [6:0]  new_y;
  logic [1:0]  new_heading;
  logic [23:0] painted_color;
  logic        last;

  langton_scoreboard sb;
  int burst_left = 0;
  int requests   = 0;
  int reg_writes = 0;
  int stall_mode = STALL_NONE;
  int mode_left  = 0;
  int run_left   = 0;

  multi_ant_langton_step u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: switch between free running, random stalls and long stall runs.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
      mode_left  <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left  <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(ant_id, new_x, new_y, new_heading, painted_color, last);
  end

  task automatic send(action_t act, bit [6:0] x, bit [6:0] y, bit [23:0] col,
                      bit [3:0] slot, bit [1:0] hd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    cell_x   <= x;
    cell_y   <= y;
    color    <= col;
    ant_slot <= slot;
    heading  <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, x, y, col, slot, heading_t'(hd));
    requests++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every pending ant move has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_moves.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (40) @(posedge clk);
  endtask

  function automatic bit [23:0] paint_choice();
    case ($urandom_range(0, 3))
      0, 1:    return sb.bg_reg;
      2:       return 24'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  function automatic void pick_inside(output bit [6:0] x, output bit [6:0] y);
    x = 7'($urandom_range(0, sb.width_eff() - 1));
    y = 7'($urandom_range(0, sb.height_eff() - 1));
  endfunction

  function automatic void pick_outside(output bit [6:0] x, output bit [6:0] y);
    if (sb.width_eff() < 128) begin
      x = 7'($urandom_range(sb.width_eff(), 127));
      y = 7'($urandom);
    end else if (sb.height_eff() < 128) begin
      x = 7'($urandom);
      y = 7'($urandom_range(sb.height_eff(), 127));
    end else begin
      pick_inside(x, y);
    end
  endfunction

  // Place any unplaced active ant and write any unwritten cell under an ant, then tick.
  task automatic tick_req();
    int       n, ex, ey;
    bit [6:0] x, y;
    n = sb.active_ants();
    for (int i = 0; i < n; i++) begin
      if (!sb.ant_known[i]) begin
        pick_inside(x, y);
        send(ACT_PLACE_ANT, x, y, 24'($urandom), 4'(i), 2'($urandom));
      end
      ex = (sb.ants[i].x < sb.width_eff()) ? int'(sb.ants[i].x) : 0;
      ey = (sb.ants[i].y < sb.height_eff()) ? int'(sb.ants[i].y) : 0;
      if (!sb.cell_known[ey * GRID_STRIDE + ex])
        send(ACT_WRITE_CELL, 7'(ex), 7'(ey), paint_choice(), 4'($urandom), 2'($urandom));
    end
    send(ACT_TICK, 7'($urandom), 7'($urandom), 24'($urandom), 4'($urandom), 2'($urandom));
  endtask

  initial begin
    bit [6:0]  x, y;
    bit [7:0]  w8, h8;
    bit [23:0] bgc;
    bit [4:0]  cnt;
    int        budget;
    sb        = new();
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = '0;
    cell_x    = '0;
    cell_y    = '0;
    color     = '0;
    ant_slot  = '0;
    heading   = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no ants yet: a tick and an unused action return nothing
    send(ACT_TICK, 7'd127, 7'd127, 24'hFFFFFF, 4'd15, 2'd3);
    send(ACT_NONE, 7'd127, 7'd127, 24'hFFFFFF, 4'd15, 2'd3);
    settle();
    // width 255 saturates, height 0 counts as one row; upper data bits ignored
    cfg_write(CFG_GRID_WIDTH, 24'hFFFFFF);
    cfg_write(CFG_GRID_HEIGHT, 24'h000100);
    cfg_write(CFG_BACKGROUND, 24'hFFFFFF);
    cfg_write(CFG_ANT_COUNT, 24'h000003);
    send(ACT_WRITE_CELL, 7'd0, 7'd0, 24'h000000, 4'd0, 2'd0);
    send(ACT_WRITE_CELL, 7'd127, 7'd0, 24'hFFFFFF, 4'd0, 2'd0);
    send(ACT_WRITE_CELL, 7'd5, 7'd1, 24'h123456, 4'd0, 2'd0);
    send(ACT_PLACE_ANT, 7'd127, 7'd0, 24'h000000, 4'd0, HD_LEFT);
    send(ACT_PLACE_ANT, 7'd0, 7'd0, 24'hA5A5A5, 4'd1, HD_UP);
    send(ACT_PLACE_ANT, 7'd64, 7'd127, 24'h5A5A5A, 4'd2, HD_DOWN);
    send(ACT_PLACE_ANT, 7'd127, 7'd0, 24'h5A5A5A, 4'd2, HD_RIGHT);
    tick_req();
    tick_req();
    tick_req();
    settle();
    // shrink the grid so ants left near column 127 sit on stale coordinates
    cfg_write(CFG_GRID_WIDTH, 24'h000004);
    cfg_write(CFG_GRID_HEIGHT, 24'h000004);
    tick_req();
    tick_req();

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          w8 = 8'd1; h8 = 8'd255; bgc = 24'h000000; cnt = 5'd16;
        end
        1: begin
          w8 = 8'd128; h8 = 8'd2; bgc = 24'hFFFFFF; cnt = 5'd31;
        end
        default: begin
          w8  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
          h8  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
          bgc = ($urandom_range(0, 1) != 0) ? 24'h000000 : 24'($urandom);
          cnt = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
        end
      endcase
      cfg_write(CFG_GRID_WIDTH, {16'($urandom), w8});
      cfg_write(CFG_GRID_HEIGHT, {16'($urandom), h8});
      cfg_write(CFG_BACKGROUND, bgc);
      cfg_write(CFG_ANT_COUNT, {19'($urandom), cnt});
      // spread the request budget evenly over the phases
      budget = 20 + (ITEM_TARGET - 20) * (p + 1) / 6;
      for (int k = 0; k < 22 && requests < budget; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: tick_req();
          9, 10, 11, 12: begin
            pick_inside(x, y);
            send(ACT_WRITE_CELL, x, y, paint_choice(), 4'($urandom), 2'($urandom));
          end
          13: begin
            pick_outside(x, y);
            send(ACT_WRITE_CELL, x, y, 24'($urandom), 4'($urandom), 2'($urandom));
          end
          14, 15, 16: begin
            pick_inside(x, y);
            send(ACT_PLACE_ANT, x, y, 24'($urandom), 4'($urandom), 2'($urandom));
          end
          17: begin
            pick_outside(x, y);
            send(ACT_PLACE_ANT, x, y, 24'($urandom), 4'($urandom), 2'($urandom));
          end
          18: send(ACT_NONE, 7'($urandom), 7'($urandom), 24'($urandom), 4'($urandom),
                   2'($urandom));
          default: begin
            drain();
            tick_req();
          end
        endcase
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d requests with %0d ticks, %0d ant moves checked, %0d register writes",
             requests, sb.ticks, sb.checked, reg_writes);
    if (sb.errors == 0) begin
      $display("tb_multi_ant_langton_step: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_multi_ant_langton_step: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d moves still pending", sb.pending_moves.size());
    $display("tb_multi_ant_langton_step: FAIL");
    $finish;
  end

endmodule
